[hdl/leader_election_voter_unit_assert.svh]
// assertion macros for the election voter unit
`ifndef LEADER_ELECTION_VOTER_UNIT_ASSERT_SVH
`define LEADER_ELECTION_VOTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define LEV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while in reset
`define LEV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lev_pkg.sv]
`default_nettype none

package lev_pkg;

  // field widths
  localparam int ID_W    = 3;
  localparam int TERM_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int KIND_W  = 3;
  localparam int ROLE_W  = 2;
  localparam int CNT_W   = 4;
  localparam int CSIZE_W = 4;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 4;

  // queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input event codes
  localparam logic [FUNC_W-1:0] FUNC_START    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_VOTE_REQ = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_VOTE_GNT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_HB_IN    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HB_TICK  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_LDR_LOST = 3'd5;

  // outgoing message kinds
  localparam logic [KIND_W-1:0] SEND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] SEND_REQ   = 3'd1;
  localparam logic [KIND_W-1:0] SEND_REPLY = 3'd2;
  localparam logic [KIND_W-1:0] SEND_ACK   = 3'd3;
  localparam logic [KIND_W-1:0] SEND_BEAT  = 3'd4;

  // node roles
  localparam logic [ROLE_W-1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_LEADER    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_SELF_ID = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_CSIZE   = 1'd1;

  // reset values of the configuration
  localparam logic [ID_W-1:0]    SELF_ID_RST = 3'd0;
  localparam logic [CSIZE_W-1:0] CSIZE_RST   = 4'd1;

  // vote counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_START,
    OP_VOTE_REQ,
    OP_VOTE_GNT,
    OP_HB_IN,
    OP_HB_TICK,
    OP_LDR_LOST,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  sender;
    logic [TERM_W-1:0] term;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hdl/lev_in_if.sv]
`default_nettype none

interface lev_in_if;
  logic                         valid;
  logic                         ready;
  logic [lev_pkg::FUNC_W-1:0]   func;
  logic [lev_pkg::ID_W-1:0]     src_id;
  logic [lev_pkg::TERM_W-1:0]   msg_term;

  modport source (output valid, output func, output src_id, output msg_term,
                  input ready);
  modport sink   (input valid, input func, input src_id, input msg_term,
                  output ready);
endinterface

`default_nettype wire

[hdl/lev_out_if.sv]
`default_nettype none

interface lev_out_if;
  logic                         valid;
  logic                         ready;
  logic [lev_pkg::KIND_W-1:0]   send_kind;
  logic [lev_pkg::ID_W-1:0]     dest_id;
  logic [lev_pkg::TERM_W-1:0]   out_term;
  logic [lev_pkg::ROLE_W-1:0]   role;
  logic                         leader_known;
  logic [lev_pkg::ID_W-1:0]     leader_node;
  logic                         became_leader;

  modport source (output valid, output send_kind, output dest_id, output out_term,
                  output role, output leader_known, output leader_node,
                  output became_leader, input ready);
  modport sink   (input valid, input send_kind, input dest_id, input out_term,
                  input role, input leader_known, input leader_node,
                  input became_leader, output ready);
endinterface

`default_nettype wire

[hdl/lev_cfg_if.sv]
`default_nettype none

interface lev_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lev_pkg::CFG_A_W-1:0]   addr;
  logic [lev_pkg::CFG_D_W-1:0]   wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

[hdl/lev_front.sv]
`default_nettype none

module lev_front (
  lev_in_if.sink           in_ch,
  input  lev_pkg::q_stat_t q_stat,
  output logic             push,
  output lev_pkg::cmd_t    push_cmd
);

  lev_pkg::op_t op;

  // decode the event code into an operation
  always_comb begin
    case (in_ch.func)
      lev_pkg::FUNC_START:    op = lev_pkg::OP_START;
      lev_pkg::FUNC_VOTE_REQ: op = lev_pkg::OP_VOTE_REQ;
      lev_pkg::FUNC_VOTE_GNT: op = lev_pkg::OP_VOTE_GNT;
      lev_pkg::FUNC_HB_IN:    op = lev_pkg::OP_HB_IN;
      lev_pkg::FUNC_HB_TICK:  op = lev_pkg::OP_HB_TICK;
      lev_pkg::FUNC_LDR_LOST: op = lev_pkg::OP_LDR_LOST;
      default:                op = lev_pkg::OP_NOP;
    endcase
  end

  // take a beat whenever the queue has room
  assign in_ch.ready     = !q_stat.full;
  assign push            = in_ch.valid && !q_stat.full;
  assign push_cmd.op     = op;
  assign push_cmd.sender = in_ch.src_id;
  assign push_cmd.term   = in_ch.msg_term;

endmodule

`default_nettype wire

[hdl/lev_queue.sv]
`default_nettype none

module lev_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lev_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output lev_pkg::cmd_t    head,
  output lev_pkg::q_stat_t q_stat
);

  lev_pkg::cmd_t                  slot_r [lev_pkg::Q_DEPTH];
  logic [lev_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lev_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lev_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lev_pkg::Q_PTR_W'(lev_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lev_pkg::Q_PTR_W'(lev_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == lev_pkg::Q_CNT_W'(lev_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

[hdl/lev_back.sv]
`default_nettype none

module lev_back (
  input  logic             clk,
  input  logic             rst_n,
  lev_cfg_if.sink          cfg_ch,
  lev_out_if.source        out_ch,
  input  lev_pkg::q_stat_t q_stat,
  input  lev_pkg::cmd_t    head,
  output logic             pop
);

  // configuration
  logic [lev_pkg::ID_W-1:0]    self_id_r;
  logic [lev_pkg::CSIZE_W-1:0] csize_r;

  // election state
  logic [lev_pkg::TERM_W-1:0]  term_r, term_nxt;
  logic                        vote_cast_r, vote_cast_nxt;
  logic [lev_pkg::ID_W-1:0]    vote_tgt_r, vote_tgt_nxt;
  logic [lev_pkg::ROLE_W-1:0]  role_r, role_nxt;
  logic [lev_pkg::CNT_W-1:0]   vote_cnt_r, vote_cnt_nxt;
  logic                        ldr_valid_r, ldr_valid_nxt;
  logic [lev_pkg::ID_W-1:0]    ldr_id_r, ldr_id_nxt;

  // result register
  logic                        out_valid_r;
  logic [lev_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [lev_pkg::ID_W-1:0]    dest_r, dest_nxt;
  logic [lev_pkg::TERM_W-1:0]  oterm_r, oterm_nxt;
  logic                        made_ldr_r, made_ldr_nxt;
  logic [lev_pkg::ROLE_W-1:0]  role_out_r;
  logic                        ldr_valid_out_r;
  logic [lev_pkg::ID_W-1:0]    ldr_id_out_r;

  logic                        term_gt, term_eq;
  logic [lev_pkg::TERM_W-1:0]  term_inc;
  logic [lev_pkg::CNT_W-1:0]   cnt_inc;

  // the back side takes the queue head when the result slot frees up
  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= lev_pkg::SELF_ID_RST;
      csize_r   <= lev_pkg::CSIZE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        lev_pkg::CFG_SELF_ID: self_id_r <= cfg_ch.wdata[lev_pkg::ID_W-1:0];
        lev_pkg::CFG_CSIZE:   csize_r   <= cfg_ch.wdata[lev_pkg::CSIZE_W-1:0];
        default:              ;
      endcase
    end
  end

  assign term_gt  = head.term > term_r;
  assign term_eq  = head.term == term_r;
  assign term_inc = term_r + 1'b1;
  assign cnt_inc  = (vote_cnt_r == lev_pkg::CNT_MAX) ? vote_cnt_r : vote_cnt_r + 1'b1;

  // apply one event to the election state
  always_comb begin
    term_nxt      = term_r;
    vote_cast_nxt = vote_cast_r;
    vote_tgt_nxt  = vote_tgt_r;
    role_nxt      = role_r;
    vote_cnt_nxt  = vote_cnt_r;
    ldr_valid_nxt = ldr_valid_r;
    ldr_id_nxt    = ldr_id_r;
    kind_nxt      = lev_pkg::SEND_NONE;
    dest_nxt      = '0;
    oterm_nxt     = '0;
    made_ldr_nxt  = 1'b0;
    case (head.op)
      lev_pkg::OP_START: begin
        term_nxt      = term_inc;
        vote_cast_nxt = 1'b1;
        vote_tgt_nxt  = self_id_r;
        role_nxt      = lev_pkg::ROLE_CANDIDATE;
        vote_cnt_nxt  = lev_pkg::CNT_W'(1);
        kind_nxt      = lev_pkg::SEND_REQ;
        oterm_nxt     = term_inc;
      end
      lev_pkg::OP_VOTE_REQ: begin
        if (term_gt || (term_eq && !vote_cast_r)) begin
          term_nxt      = head.term;
          vote_cast_nxt = 1'b1;
          vote_tgt_nxt  = head.sender;
          role_nxt      = lev_pkg::ROLE_FOLLOWER;
          kind_nxt      = lev_pkg::SEND_REPLY;
          dest_nxt      = head.sender;
          oterm_nxt     = head.term;
        end
      end
      lev_pkg::OP_VOTE_GNT: begin
        if (role_r == lev_pkg::ROLE_CANDIDATE && term_eq) begin
          vote_cnt_nxt = cnt_inc;
          // strict majority of the cluster
          if (cnt_inc > (csize_r >> 1)) begin
            role_nxt      = lev_pkg::ROLE_LEADER;
            ldr_valid_nxt = 1'b1;
            ldr_id_nxt    = self_id_r;
            made_ldr_nxt  = 1'b1;
          end
        end
      end
      lev_pkg::OP_HB_IN: begin
        if (term_gt || term_eq) begin
          ldr_valid_nxt = 1'b1;
          ldr_id_nxt    = head.sender;
          term_nxt      = head.term;
          role_nxt      = lev_pkg::ROLE_FOLLOWER;
        end
        kind_nxt  = lev_pkg::SEND_ACK;
        dest_nxt  = head.sender;
        oterm_nxt = head.term;
      end
      lev_pkg::OP_HB_TICK: begin
        if (role_r == lev_pkg::ROLE_LEADER) begin
          kind_nxt  = lev_pkg::SEND_BEAT;
          oterm_nxt = term_r;
        end
      end
      lev_pkg::OP_LDR_LOST: begin
        ldr_valid_nxt = 1'b0;
        if (role_r == lev_pkg::ROLE_FOLLOWER) begin
          term_nxt      = term_inc;
          vote_cast_nxt = 1'b1;
          vote_tgt_nxt  = self_id_r;
          role_nxt      = lev_pkg::ROLE_CANDIDATE;
          vote_cnt_nxt  = lev_pkg::CNT_W'(1);
          kind_nxt      = lev_pkg::SEND_REQ;
          oterm_nxt     = term_inc;
        end
      end
      default: ;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r      <= '0;
      vote_cast_r <= 1'b0;
      vote_tgt_r  <= '0;
      role_r      <= lev_pkg::ROLE_FOLLOWER;
      vote_cnt_r  <= '0;
      ldr_valid_r <= 1'b0;
      ldr_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        term_r      <= term_nxt;
        vote_cast_r <= vote_cast_nxt;
        vote_tgt_r  <= vote_tgt_nxt;
        role_r      <= role_nxt;
        vote_cnt_r  <= vote_cnt_nxt;
        ldr_valid_r <= ldr_valid_nxt;
        ldr_id_r    <= ldr_id_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r          <= kind_nxt;
      dest_r          <= dest_nxt;
      oterm_r         <= oterm_nxt;
      made_ldr_r      <= made_ldr_nxt;
      role_out_r      <= role_nxt;
      ldr_valid_out_r <= ldr_valid_nxt;
      ldr_id_out_r    <= ldr_id_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.send_kind     = kind_r;
  assign out_ch.dest_id       = dest_r;
  assign out_ch.out_term      = oterm_r;
  assign out_ch.role          = role_out_r;
  assign out_ch.leader_known  = ldr_valid_out_r;
  assign out_ch.leader_node   = ldr_id_out_r;
  assign out_ch.became_leader = made_ldr_r;

endmodule

`default_nettype wire

[hdl/leader_election_voter_unit.sv]
`default_nettype none

// Election state of one cluster node. Each event beat on in_ch yields exactly
// one result beat on out_ch naming the message to send, together with the role
// and known leader after the event. One event is taken per cycle in steady
// state while out_ch is ready; the rate is set by the back unit's state update,
// which applies one event a cycle. An accepted event is written into the
// two-entry command queue; its result is registered from the head and held
// until out_ch takes it. While out_ch stalls, the output register and the queue
// hold three events before in_ch.ready drops. Configuration (self_id at index
// 0, cluster_size at index 1) must be written on cfg_ch only while no events
// are in flight, not enforced by the block; reset: self_id 0, cluster_size 1.

module leader_election_voter_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lev_in_if.sink      in_ch,
  lev_out_if.source   out_ch,
  lev_cfg_if.sink     cfg_ch
);

  lev_pkg::q_stat_t q_stat;
  lev_pkg::cmd_t    push_cmd;
  lev_pkg::cmd_t    head;
  logic             push;
  logic             pop;

  // classify incoming events
  lev_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple front from back
  lev_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // apply events and register results
  lev_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop)
  );

`include "leader_election_voter_unit_assert.svh"

  `LEV_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
  `LEV_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
  `LEV_ASSERT_NOW(a_became_leader, out_ch.valid && out_ch.became_leader,
    (out_ch.role == lev_pkg::ROLE_LEADER) && out_ch.leader_known, "leader flags disagree")
  `LEV_ASSERT_NOW(a_beat_by_leader, out_ch.valid && (out_ch.send_kind == lev_pkg::SEND_BEAT),
    out_ch.role == lev_pkg::ROLE_LEADER, "heartbeat sent by non-leader")
  `LEV_ASSERT_NEXT(a_empty_pop, q_stat.empty && !push, !pop, "pop without queued event")

endmodule

`default_nettype wire
